// File: rtl/hue_sat_grey_to_rgb_unit_macros.svh
// Assertion macros for the hue/saturation/grey to RGB unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef HUE_SAT_GREY_TO_RGB_UNIT_MACROS_SVH
`define HUE_SAT_GREY_TO_RGB_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define HSGR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hsgr assertion failed");
`define HSGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsgr assertion failed");
`else
`define HSGR_ASSERT(lbl, clk, rst_n, prop)
`define HSGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/hsgr_pkg.sv
// Shared types and constants for the hue/saturation/grey to RGB unit.
// No dependencies.
`default_nettype none

package hsgr_pkg;

	localparam int FIELD_W  = 16;
	localparam int BEAT_W   = 4 * FIELD_W;
	localparam int SAT_FRAC = 14;
	localparam int SAT_W    = SAT_FRAC + 1;
	localparam int SAT_ONE  = 1 << SAT_FRAC;
	localparam int SAT_HALF = 1 << (SAT_FRAC - 1);

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

endpackage

`default_nettype wire

// File: rtl/hsgr_blend.sv
// One channel blend: grey + sat * (ramp - grey), rounded and saturated.
// Depends on hsgr_pkg.
`default_nettype none

module hsgr_blend #(
	parameter int C = 16
) (
	input  wire logic [hsgr_pkg::SAT_W-1:0]   sat,
	input  wire logic signed [C+1:0]          diff,
	input  wire logic [C-1:0]                 grey,
	output logic [hsgr_pkg::FIELD_W-1:0]      chan
);
	import hsgr_pkg::*;

	localparam int PW = C + 4 + SAT_FRAC;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] acc;
	logic [C:0]           val;
	logic [C-1:0]         chan_c;

	always_comb begin
		prod   = PW'($signed({1'b0, sat}) * diff);
		acc    = prod + $signed({4'b0, grey, {SAT_FRAC{1'b0}}}) + $signed(PW'(SAT_HALF));
		val    = acc[C+SAT_FRAC:SAT_FRAC];
		chan_c = val[C] ? {C{1'b1}} : val[C-1:0];
		chan   = FIELD_W'(chan_c);
	end

endmodule

`default_nettype wire

// File: rtl/hue_sat_grey_to_rgb_unit.sv
// Top level of the hue/saturation/grey to RGB unit.
// Depends on hsgr_pkg, hsgr_blend and hue_sat_grey_to_rgb_unit_macros.svh.
//
// Channel  Dir  tdata fields (low to high)
// s_*      in   hue_turn, saturation, grey_level, alpha_in (16 bits each)
// m_*      out  red, green, blue, alpha_out (16 bits each)
//
// One beat per cycle sustained while the output is not stalled; each beat passes through the stages below in order.
// Stages: input register, sector/ramp/difference register, result register
// after the three channel multipliers.
// Reset clears the stage valid bits only; the unit is stateless.
// Each stage holds while the one after it is full and stalled.
`default_nettype none

module hue_sat_grey_to_rgb_unit #(
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [hsgr_pkg::BEAT_W-1:0]  s_tdata,  // hue_turn, saturation, grey_level, alpha_in
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [hsgr_pkg::BEAT_W-1:0]       m_tdata   // red, green, blue, alpha_out
);
	import hsgr_pkg::*;

	`include "hue_sat_grey_to_rgb_unit_macros.svh"

	localparam int C = CHANNEL_BITS;

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	logic [FIELD_W-1:0] hue_s1, sat_raw_s1, grey_raw_s1, alpha_s1;

	logic [SAT_W-1:0]   sat_s2;
	logic signed [C+1:0] diff_r_s2, diff_g_s2, diff_b_s2;
	logic [C-1:0]       grey_s2;
	logic [FIELD_W-1:0] alpha_s2;

	logic [FIELD_W-1:0] red_s3, green_s3, blue_s3, alpha_s3;

	logic [C-1:0]       h;
	logic [C+2:0]       prod6;
	logic [C-1:0]       d;
	logic [C:0]         d_up, d_down;
	logic [C:0]         ramp_r, ramp_g, ramp_b;
	logic [C-1:0]       grey_c;
	logic [SAT_W-1:0]   sat_c;
	sector_t            sector;
	logic [FIELD_W-1:0] red_c, green_c, blue_c;

	localparam logic [C:0] RAMP_ONE = {1'b1, {C{1'b0}}};

	assign ready_s3 = !valid_s3 || m_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			hue_s1      <= s_tdata[FIELD_W-1:0];
			sat_raw_s1  <= s_tdata[2*FIELD_W-1:FIELD_W];
			grey_raw_s1 <= s_tdata[3*FIELD_W-1:2*FIELD_W];
			alpha_s1    <= s_tdata[4*FIELD_W-1:3*FIELD_W];
		end
	end

	always_comb begin
		h       = C'(hue_s1);
		grey_c  = C'(grey_raw_s1);
		prod6   = (C+3)'({h, 2'b0}) + (C+3)'({h, 1'b0});
		sector  = sector_t'(prod6[C+2:C]);
		d       = prod6[C-1:0];
		d_up    = {1'b0, d};
		d_down  = RAMP_ONE - d_up;
		priority if (sat_raw_s1[FIELD_W-1])
			sat_c = '0;
		else if (sat_raw_s1[SAT_W-1:0] > SAT_W'(SAT_ONE))
			sat_c = SAT_W'(SAT_ONE);
		else
			sat_c = sat_raw_s1[SAT_W-1:0];
		unique case (sector)
			SEC_0: begin
				ramp_r = d_up;     ramp_g = '0;       ramp_b = RAMP_ONE;
			end
			SEC_1: begin
				ramp_r = RAMP_ONE; ramp_g = '0;       ramp_b = d_down;
			end
			SEC_2: begin
				ramp_r = RAMP_ONE; ramp_g = d_up;     ramp_b = '0;
			end
			SEC_3: begin
				ramp_r = d_down;   ramp_g = RAMP_ONE; ramp_b = '0;
			end
			SEC_4: begin
				ramp_r = '0;       ramp_g = RAMP_ONE; ramp_b = d_up;
			end
			default: begin
				ramp_r = '0;       ramp_g = d_down;   ramp_b = RAMP_ONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sat_s2    <= sat_c;
			grey_s2   <= grey_c;
			alpha_s2  <= FIELD_W'(C'(alpha_s1));
			diff_r_s2 <= $signed({1'b0, ramp_r}) - $signed({2'b0, grey_c});
			diff_g_s2 <= $signed({1'b0, ramp_g}) - $signed({2'b0, grey_c});
			diff_b_s2 <= $signed({1'b0, ramp_b}) - $signed({2'b0, grey_c});
		end
	end

	hsgr_blend #(.C(C)) u_blend_r (
		.sat  (sat_s2),
		.diff (diff_r_s2),
		.grey (grey_s2),
		.chan (red_c)
	);

	hsgr_blend #(.C(C)) u_blend_g (
		.sat  (sat_s2),
		.diff (diff_g_s2),
		.grey (grey_s2),
		.chan (green_c)
	);

	hsgr_blend #(.C(C)) u_blend_b (
		.sat  (sat_s2),
		.diff (diff_b_s2),
		.grey (grey_s2),
		.chan (blue_c)
	);

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			red_s3   <= red_c;
			green_s3 <= green_c;
			blue_s3  <= blue_c;
			alpha_s3 <= alpha_s2;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {alpha_s3, blue_s3, green_s3, red_s3};

	`HSGR_ASSERT(a_sat_clamped, clk, arst_n, !valid_s2 || sat_s2 <= SAT_W'(SAT_ONE))
	`HSGR_ASSERT_NEXT(a_no_invented_beat, clk, arst_n, m_tvalid && m_tready && !valid_s2,
		!m_tvalid)
	`HSGR_ASSERT_NEXT(a_alpha_carried, clk, arst_n, valid_s2 && ready_s3,
		m_tdata[4*FIELD_W-1:3*FIELD_W] == $past(alpha_s2))
	`HSGR_ASSERT_NEXT(a_s2_hold, clk, arst_n, valid_s2 && !ready_s2,
		valid_s2 && $stable(diff_r_s2) && $stable(sat_s2))

endmodule

`default_nettype wire

// File: tb/sv/hue_sat_grey_to_rgb_unit_tb.sv
// Self-checking testbench for hue_sat_grey_to_rgb_unit: HSV-style beats in, RGBA beats out.
// Predicts each pixel in-line and compares in order; depends on hsgr_pkg and the unit RTL.
module hue_sat_grey_to_rgb_unit_tb;
	import hsgr_pkg::*;

	localparam int HOLD_LEN = 200;

	typedef struct packed {
		logic [FIELD_W-1:0] alpha;
		logic [FIELD_W-1:0] blue;
		logic [FIELD_W-1:0] green;
		logic [FIELD_W-1:0] red;
	} rgba_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BEAT_W-1:0]  s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [BEAT_W-1:0]  m_tdata;

	rgba_t rgb_expected [$];
	int    mismatches  = 0;
	int    send_idle   = 0;
	int    recv_stall  = 0;
	logic  hold_toggle = 1'b0;
	logic  hold_ack    = 1'b0;
	int    hold_left   = 0;

	hue_sat_grey_to_rgb_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [FIELD_W-1:0] blend_chan(input logic [FIELD_W:0] ramp,
			input logic [SAT_W-1:0] sat, input logic [FIELD_W-1:0] grey);
		logic [31:0] acc;
		logic [17:0] val;
		acc = sat * ramp + (SAT_ONE - sat) * grey + SAT_HALF;
		val = 18'(acc >> SAT_FRAC);
		if (val > 18'h0FFFF) begin
			return 16'hFFFF;
		end
		return val[FIELD_W-1:0];
	endfunction

	function automatic rgba_t hsv_to_rgba(input logic [BEAT_W-1:0] beat);
		logic [FIELD_W-1:0] hue;
		logic [FIELD_W-1:0] sraw;
		logic [FIELD_W-1:0] grey;
		logic [SAT_W-1:0]   sat;
		logic [18:0]        prod;
		logic [FIELD_W-1:0] frac;
		logic [FIELD_W:0]   one;
		logic [FIELD_W:0]   r;
		logic [FIELD_W:0]   g;
		logic [FIELD_W:0]   b;
		sector_t            sec;
		rgba_t              px;
		hue  = beat[15:0];
		sraw = beat[31:16];
		grey = beat[47:32];
		if (sraw[15]) begin
			sat = '0;
		end else if (sraw > SAT_ONE) begin
			sat = SAT_W'(SAT_ONE);
		end else begin
			sat = sraw[SAT_W-1:0];
		end
		prod = 19'(hue) * 19'd6;
		sec  = sector_t'(prod[18:16]);
		frac = prod[15:0];
		one  = 17'h10000;
		case (sec)
			SEC_0: begin
				r = {1'b0, frac}; g = '0; b = one;
			end
			SEC_1: begin
				r = one; g = '0; b = one - {1'b0, frac};
			end
			SEC_2: begin
				r = one; g = {1'b0, frac}; b = '0;
			end
			SEC_3: begin
				r = one - {1'b0, frac}; g = one; b = '0;
			end
			SEC_4: begin
				r = '0; g = one; b = {1'b0, frac};
			end
			default: begin
				r = '0; g = one - {1'b0, frac}; b = one;
			end
		endcase
		px.red   = blend_chan(r, sat, grey);
		px.green = blend_chan(g, sat, grey);
		px.blue  = blend_chan(b, sat, grey);
		px.alpha = beat[63:48];
		return px;
	endfunction

	always @(posedge clk) begin : beat_monitor
		rgba_t exp_px;
		rgba_t got_px;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_px = rgba_t'(m_tdata);
				if (rgb_expected.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %h", $time, got_px);
					mismatches++;
				end else begin
					exp_px = rgb_expected.pop_front();
					if (got_px.red !== exp_px.red) begin
						$display("%0t: red expected %h actual %h", $time, exp_px.red, got_px.red);
						mismatches++;
					end
					if (got_px.green !== exp_px.green) begin
						$display("%0t: green expected %h actual %h", $time,
							exp_px.green, got_px.green);
						mismatches++;
					end
					if (got_px.blue !== exp_px.blue) begin
						$display("%0t: blue expected %h actual %h", $time,
							exp_px.blue, got_px.blue);
						mismatches++;
					end
					if (got_px.alpha !== exp_px.alpha) begin
						$display("%0t: alpha expected %h actual %h", $time,
							exp_px.alpha, got_px.alpha);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				rgb_expected.push_back(hsv_to_rgba(s_tdata));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_ack != hold_toggle) begin
			hold_ack  <= hold_toggle;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic offer_pixel(input logic [15:0] hue, input logic [15:0] sat,
			input logic [15:0] grey, input logic [15:0] alpha);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {alpha, grey, sat, hue};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (rgb_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_level();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_saturation();
		case ($urandom_range(9))
			0, 1, 2, 3: return 16'($urandom_range(SAT_ONE));
			4, 5:       return 16'($urandom_range(32767, SAT_ONE + 1));
			6, 7:       return 16'h8000 | 16'($urandom_range(32767));
			8:          return ($urandom_range(1) != 0) ? 16'(SAT_ONE) : 16'h0000;
			default:    return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_idle  = 0;
		recv_stall <= 0;
		offer_pixel(16'd0,     16'd16384, 16'h0000, 16'h0000);
		offer_pixel(16'hFFFF,  16'd16384, 16'h0000, 16'hFFFF);
		offer_pixel(16'd10922, 16'd16384, 16'h0000, 16'h1234);
		offer_pixel(16'd10923, 16'd16384, 16'h0000, 16'h5678);
		offer_pixel(16'd21845, 16'd16384, 16'hFFFF, 16'h9ABC);
		offer_pixel(16'd21846, 16'd16384, 16'hFFFF, 16'hDEF0);
		offer_pixel(16'd32767, 16'd16384, 16'h8000, 16'h0001);
		offer_pixel(16'd32768, 16'd16384, 16'h8000, 16'h8000);
		offer_pixel(16'd43690, 16'd16384, 16'h4000, 16'h7FFF);
		offer_pixel(16'd43691, 16'd16384, 16'h4000, 16'hAAAA);
		offer_pixel(16'd54613, 16'd16384, 16'h0000, 16'h5555);
		offer_pixel(16'd54614, 16'd16384, 16'h0000, 16'h0F0F);
		offer_pixel(16'h4000,  16'h8000,  16'hFFFF, 16'h0000);
		offer_pixel(16'h4000,  16'hFFFF,  16'h1234, 16'hFFFF);
		offer_pixel(16'h9000,  16'd16385, 16'h8000, 16'h1111);
		offer_pixel(16'h9000,  16'h7FFF,  16'hFFFF, 16'h2222);
		offer_pixel(16'h2000,  16'd0,     16'hFFFF, 16'h3333);
		offer_pixel(16'h2000,  16'd8192,  16'hFFFF, 16'h4444);
		offer_pixel(16'h7000,  16'd8192,  16'h8001, 16'h6666);
		offer_pixel(16'hC000,  16'd1,     16'hFFFF, 16'h7777);
		offer_pixel(16'hFFFF,  16'd16383, 16'hFFFF, 16'hFFFF);
		wait_results_drained();
	endtask

	task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
		send_idle  = idle_pct;
		recv_stall <= stall_pct;
		repeat (count) begin
			offer_pixel(pick_level(), pick_saturation(), pick_level(), 16'($urandom));
		end
	endtask

	task automatic test_receiver_holdoff();
		send_idle   = 0;
		recv_stall  <= 0;
		hold_toggle <= ~hold_toggle;
		repeat (60) begin
			offer_pixel(pick_level(), pick_saturation(), pick_level(), 16'($urandom));
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream(350, 0, 0);
		test_random_stream(350, 59, 0);
		wait_results_drained();
		test_receiver_holdoff();
		test_random_stream(350, 0, 59);
		test_random_stream(350, 15, 15);
		recv_stall <= 0;
		wait_results_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("hue_sat_grey_to_rgb_unit: match");
		end else begin
			$display("hue_sat_grey_to_rgb_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("hue_sat_grey_to_rgb_unit: mismatch");
		$finish;
	end

endmodule
